// ===== src/srvo_pkg.sv =====
// srvo_pkg: shared types and constants for the srv record orderer
// no dependencies
package srvo_pkg;
	localparam int MaxRecords = 32;
	localparam int IdxW = $clog2(MaxRecords);
	localparam int CntW = $clog2(MaxRecords + 1);
	localparam int RecW = 64;
	localparam int SumW = 16 + IdxW;
	localparam logic [31:0] LfsrTaps = 32'h8020_0003;

	typedef enum logic [3:0] {
		ST_LOAD, ST_SORT, ST_GRP, ST_PART, ST_SUM, ST_DRAW, ST_DIV, ST_SCAN, ST_PLACE,
		ST_NEXTG, ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_rec;
		logic start_run;
		logic sort_step;
		logic grp_step;
		logic part_step;
		logic sum_step;
		logic draw;
		logic div_step;
		logic scan_step;
		logic place;
		logic next_grp;
		logic emit_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sort_done;
		logic grp_done;
		logic grp_single;
		logic part_done;
		logic sum_done;
		logic div_done;
		logic scan_done;
		logic picks_done;
		logic all_done;
		logic emit_last;
	} sts_t;

	function automatic logic [31:0] lfsr_adv(input logic [31:0] s);
		lfsr_adv = (s >> 1) ^ (s[0] ? LfsrTaps : 32'h0);
	endfunction
endpackage

// ===== src/srv_record_priority_weight_order.sv =====
// srv record orderer: loads records one beat per cycle while idle; the closing beat starts a run
// sort by priority, insertion with one shift a cycle
// each equal-priority group of g > 1: find its end, partition zero weights first and sum,
// then per pick one draw, a restoring remainder, a scan of the running sums and one place
// output one beat per cycle while m_tready is high; next set taken after the last beat leaves
// async active-low reset: empty store, seed 1, generator state 1
module srv_record_priority_weight_order import srvo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // rec_priority, rec_weight, rec_port, rec_tag
	input  logic        s_tlast,   // rec_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_priority, out_weight, out_port, out_tag
	output logic        m_tuser,   // out_truncated
	output logic        m_tlast,   // out_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // random_seed
);
	cmd_t cmd;
	sts_t sts;
	logic [31:0] seed_q;
	logic [63:0] rec, orec;
	logic in_beat;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= 32'd1;
		else if (cfg_valid) seed_q <= cfg_data;
	end

	// store layout: priority in the top bits, tag at the bottom
	assign rec = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]};
	assign in_beat = s_tvalid && s_tready;

	srvo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat), .in_last(s_tlast),
		.out_rdy(m_tready), .sts(sts), .cmd(cmd), .in_rdy(s_tready), .out_vld(m_tvalid)
	);

	srvo_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_rec(rec),
		.in_valid_beat(in_beat), .seed(seed_q), .out_rec(orec), .out_trunc(m_tuser)
	);

	assign m_tdata = {orec[15:0], orec[31:16], orec[47:32], orec[63:48]};
	assign m_tlast = sts.emit_last;
endmodule

// ===== src/srvo_dp.sv =====
// srvo_dp: record store, sort, weight sums, divider and pick datapath
// depends on srvo_pkg
module srvo_dp import srvo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [63:0]      in_rec,
	input  logic             in_valid_beat,
	input  logic [31:0]      seed,
	output logic [63:0]      out_rec,
	output logic             out_trunc
);
	logic [RecW-1:0] store_q [MaxRecords];
	logic [RecW-1:0] tmp_q [MaxRecords];
	logic [SumW-1:0] sums_q [MaxRecords];
	logic [MaxRecords-1:0] taken_q;
	logic [CntW-1:0] cnt_q, i_q, j_q, lo_q, hi_q, k_q, p_q, pick_q, fb_q;
	logic [1:0] phase_q;
	logic found_q, ovf_q;
	logic [31:0] rnd_q, rem_q;
	logic [SumW-1:0] sum_q;
	logic [5:0] dbit_q;

	logic [CntW-1:0] n_grp;
	assign n_grp = hi_q - lo_q + CntW'(1);

	// idx helpers
	logic [IdxW-1:0] i_ix, j_ix, jm_ix, hi1_ix, p_ix, k_ix, lok_ix, lop_ix;
	assign i_ix = i_q[IdxW-1:0];
	assign j_ix = j_q[IdxW-1:0];
	assign jm_ix = IdxW'(j_q - CntW'(1));
	assign hi1_ix = IdxW'(hi_q + CntW'(1));
	assign p_ix = p_q[IdxW-1:0];
	assign k_ix = k_q[IdxW-1:0];
	assign lok_ix = IdxW'(lo_q + k_q);
	assign lop_ix = IdxW'(lo_q + p_q);

	logic [63:0] cur_q;
	logic sort_in_q;
	logic [32:0] rem_sh;
	logic [32:0] divisor;
	assign divisor = {{(33-SumW){1'b0}}, sum_q} + 33'd1;
	assign rem_sh = {rem_q, rnd_q[31]};

	logic [15:0] wgt_p;
	assign wgt_p = store_q[lop_ix][47:32];

	assign sts.sort_done = (i_q >= cnt_q) && !sort_in_q;
	assign sts.grp_done = (hi_q + CntW'(1) >= cnt_q) ||
		(store_q[hi1_ix][63:48] != store_q[lo_q[IdxW-1:0]][63:48]);
	assign sts.grp_single = (hi_q == lo_q);
	assign sts.part_done = (phase_q == 2'd1) && (p_q == n_grp - CntW'(1));
	assign sts.sum_done = (p_q == n_grp - CntW'(1));
	assign sts.div_done = (dbit_q == 6'd31);
	assign sts.scan_done = found_q || (p_q >= n_grp);
	assign sts.picks_done = (k_q + CntW'(1) >= n_grp);
	assign sts.all_done = (hi_q + CntW'(1) >= cnt_q);
	assign sts.emit_last = (i_q + CntW'(1) == cnt_q);
	assign out_rec = store_q[i_ix];
	assign out_trunc = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; ovf_q <= 1'b0; taken_q <= '0; rnd_q <= 32'd1;
			i_q <= '0; j_q <= '0; lo_q <= '0; hi_q <= '0; k_q <= '0; p_q <= '0;
			phase_q <= '0; found_q <= 1'b0; sort_in_q <= 1'b0; dbit_q <= '0;
			sum_q <= '0; rem_q <= '0; pick_q <= '0; fb_q <= '0; cur_q <= '0;
		end else begin
			if (cmd.load_rec && in_valid_beat) begin
				if (cnt_q < CntW'(MaxRecords)) begin
					store_q[cnt_q[IdxW-1:0]] <= in_rec;
					cnt_q <= cnt_q + CntW'(1);
				end else ovf_q <= 1'b1;
			end
			if (cmd.start_run) begin
				rnd_q <= (seed == 32'd0) ? 32'd1 : seed;
				i_q <= CntW'(1); sort_in_q <= 1'b0;
			end
			// one insertion shift per cycle
			if (cmd.sort_step) begin
				if (!sort_in_q) begin
					cur_q <= store_q[i_ix]; j_q <= i_q; sort_in_q <= 1'b1;
				end else if (j_q != '0 && store_q[jm_ix][63:48] > cur_q[63:48]) begin
					store_q[j_ix] <= store_q[jm_ix]; j_q <= j_q - CntW'(1);
				end else begin
					store_q[j_ix] <= cur_q; sort_in_q <= 1'b0; i_q <= i_q + CntW'(1);
				end
			end
			if (cmd.grp_step) hi_q <= hi_q + CntW'(1);
			if (cmd.part_step) begin
				if ((wgt_p == 16'd0) == (phase_q == 2'd0)) begin
					tmp_q[k_ix] <= store_q[lop_ix];
					if (!sts.part_done) k_q <= k_q + CntW'(1);
				end
				if (p_q == n_grp - CntW'(1)) begin
					p_q <= '0; phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd1) begin k_q <= '0; sum_q <= '0; end
				end else p_q <= p_q + CntW'(1);
			end
			if (cmd.sum_step) begin
				sums_q[p_ix] <= sum_q + SumW'(tmp_q[p_ix][47:32]);
				sum_q <= sum_q + SumW'(tmp_q[p_ix][47:32]);
				p_q <= sts.sum_done ? '0 : p_q + CntW'(1);
			end
			if (cmd.draw) begin
				rnd_q <= lfsr_adv(rnd_q); rem_q <= '0; dbit_q <= '0;
			end
			// restoring divide, one quotient bit per cycle, rnd_q rotated
			if (cmd.div_step) begin
				rem_q <= (rem_sh >= divisor) ? 32'(rem_sh - divisor) : rem_sh[31:0];
				rnd_q <= {rnd_q[30:0], rnd_q[31]};
				dbit_q <= dbit_q + 6'd1;
				if (sts.div_done) begin p_q <= '0; found_q <= 1'b0; fb_q <= '0; end
			end
			if (cmd.scan_step) begin
				if (!taken_q[p_ix]) begin
					if (32'(sums_q[p_ix]) >= rem_q) begin
						found_q <= 1'b1; pick_q <= p_q;
					end else fb_q <= p_q;
				end
				if (!(!taken_q[p_ix] && 32'(sums_q[p_ix]) >= rem_q)) p_q <= p_q + CntW'(1);
			end
			if (cmd.place) begin
				store_q[lok_ix] <= tmp_q[found_q ? pick_q[IdxW-1:0] : fb_q[IdxW-1:0]];
				taken_q[found_q ? pick_q[IdxW-1:0] : fb_q[IdxW-1:0]] <= 1'b1;
				k_q <= k_q + CntW'(1);
			end
			if (cmd.next_grp) begin
				lo_q <= hi_q + CntW'(1); hi_q <= hi_q + CntW'(1);
				taken_q <= '0; k_q <= '0; p_q <= '0; phase_q <= '0;
			end
			if (cmd.sort_step && sts.sort_done) begin
				lo_q <= '0; hi_q <= '0; k_q <= '0; p_q <= '0; phase_q <= '0;
			end
			if (cmd.sort_step && sts.sort_done) i_q <= '0;
			if (cmd.emit_step && !cmd.finish) i_q <= i_q + CntW'(1);
			if (cmd.finish) begin
				cnt_q <= '0; ovf_q <= 1'b0; taken_q <= '0; i_q <= '0;
			end
		end
	end
endmodule

// ===== src/srvo_ctrl.sv =====
// srvo_ctrl: run sequencer for load, sort, group ordering and emit
// depends on srvo_pkg
module srvo_ctrl import srvo_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_beat,
	input  logic   in_last,
	input  logic   out_rdy,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   in_rdy,
	output logic   out_vld
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_rdy = 1'b1;
				cmd.load_rec = 1'b1;
				if (in_beat && in_last) begin
					cmd.start_run = 1'b1; state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
				if (sts.sort_done) state_d = ST_GRP;
			end
			ST_GRP: begin
				if (sts.grp_done) state_d = sts.grp_single ? ST_NEXTG : ST_PART;
				else cmd.grp_step = 1'b1;
			end
			ST_PART: begin
				cmd.part_step = 1'b1;
				if (sts.part_done) state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_done) state_d = ST_DRAW;
			end
			ST_DRAW: begin cmd.draw = 1'b1; state_d = ST_DIV; end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_PLACE;
				else cmd.scan_step = 1'b1;
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d = sts.picks_done ? ST_NEXTG : ST_DRAW;
			end
			ST_NEXTG: begin
				if (sts.all_done) state_d = ST_EMIT;
				else begin cmd.next_grp = 1'b1; state_d = ST_GRP; end
			end
			ST_EMIT: begin
				out_vld = 1'b1;
				if (out_rdy) begin
					cmd.emit_step = 1'b1;
					if (sts.emit_last) begin cmd.finish = 1'b1; state_d = ST_LOAD; end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule

// ===== verif/tb_srv_record_priority_weight_order.sv =====
// testbench for the srv record orderer: records in, priority-sorted weighted order out
// depends on srvo_pkg and srv_record_priority_weight_order; self-checking via a local predictor
module tb_srv_record_priority_weight_order;
	import srvo_pkg::*;

	typedef struct packed {
		logic [15:0] prio;
		logic [15:0] wgt;
		logic [15:0] port;
		logic [15:0] tag;
	} srv_rec_t;

	typedef struct packed {
		srv_rec_t rec;
		logic     trunc;
		logic     last;
	} ordered_t;

	// one row of the directed table; has_exp marks a typed-in expectation
	typedef struct {
		srv_rec_t rec;
		logic     last;
		logic     has_exp;
		ordered_t exp_beat;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // rec_priority, rec_weight, rec_port, rec_tag
	logic        s_tlast;   // rec_last
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // out_priority, out_weight, out_port, out_tag
	logic        m_tuser;   // out_truncated
	logic        m_tlast;   // out_last
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;  // random_seed

	srv_record_priority_weight_order dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	srv_rec_t    held_recs[MaxRecords];
	int          held_count;
	logic        dropped;
	logic [31:0] seed_reg;
	logic [31:0] gen_state;
	ordered_t    order_q[$];

	int errors;
	int beats_in;
	int beats_out;
	int sets_done;

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	function automatic logic [31:0] gen_step(input logic [31:0] s);
		logic [31:0] t;
		t = s >> 1;
		if (s[0]) t = t ^ 32'h8020_0003;
		return t;
	endfunction

	// weighted pick within one equal-priority group held_recs[lo..hi]
	task automatic shuffle_group(input int lo, input int hi);
		srv_rec_t    grp[MaxRecords];
		logic [31:0] sums[MaxRecords];
		bit          taken[MaxRecords];
		logic [31:0] total;
		logic [31:0] draw;
		int          n, k, i, pick, fallback;
		bit          found;
		n = hi - lo + 1;
		k = 0;
		total = 0;
		for (i = lo; i <= hi; i++)
			if (held_recs[i].wgt == 0) begin
				grp[k] = held_recs[i];
				k++;
			end
		for (i = lo; i <= hi; i++)
			if (held_recs[i].wgt != 0) begin
				grp[k] = held_recs[i];
				k++;
			end
		for (i = 0; i < n; i++) begin
			total = total + grp[i].wgt;
			sums[i] = total;
			taken[i] = 0;
		end
		for (k = 0; k < n; k++) begin
			gen_state = gen_step(gen_state);
			draw = gen_state % (total + 32'd1);
			pick = 0;
			fallback = 0;
			found = 0;
			for (i = 0; i < n; i++) begin
				if (taken[i]) continue;
				if (sums[i] >= draw) begin
					pick = i; found = 1; break;
				end
				fallback = i;
			end
			if (!found) pick = fallback;
			held_recs[lo + k] = grp[pick];
			taken[pick] = 1;
		end
	endtask

	// stores one accepted record; on the closing record queues the ordered set
	task automatic order_record(input srv_rec_t rec, input logic last);
		srv_rec_t cur;
		ordered_t b;
		int       i, j, st, en;
		if (held_count < MaxRecords) begin
			held_recs[held_count] = rec;
			held_count++;
		end else dropped = 1'b1;
		if (!last) return;
		gen_state = (seed_reg != 0) ? seed_reg : 32'd1;
		// stable insertion sort on priority
		for (i = 1; i < held_count; i++) begin
			cur = held_recs[i];
			j = i;
			while (j > 0 && held_recs[j-1].prio > cur.prio) begin
				held_recs[j] = held_recs[j-1];
				j--;
			end
			held_recs[j] = cur;
		end
		st = 0;
		while (st < held_count) begin
			en = st;
			while (en + 1 < held_count && held_recs[en+1].prio == held_recs[st].prio) en++;
			if (en > st) shuffle_group(st, en);
			st = en + 1;
		end
		for (i = 0; i < held_count; i++) begin
			b.rec = held_recs[i];
			b.trunc = dropped;
			b.last = (i + 1 == held_count);
			order_q.push_back(b);
		end
		held_count = 0;
		dropped = 1'b0;
	endtask

	// output side: random stalls, compare each beat with the oldest expectation
	initial begin
		ordered_t e;
		srv_rec_t got;
		int       gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48]};
			beats_out++;
			if (order_q.size() == 0) begin
				$error("unexpected beat: tdata %h", m_tdata);
				errors++;
			end else begin
				e = order_q.pop_front();
				if (got.prio !== e.rec.prio) begin
					$error("out_priority exp %h got %h", e.rec.prio, got.prio); errors++;
				end
				if (got.wgt !== e.rec.wgt) begin
					$error("out_weight exp %h got %h", e.rec.wgt, got.wgt); errors++;
				end
				if (got.port !== e.rec.port) begin
					$error("out_port exp %h got %h", e.rec.port, got.port); errors++;
				end
				if (got.tag !== e.rec.tag) begin
					$error("out_tag exp %h got %h", e.rec.tag, got.tag); errors++;
				end
				if (m_tuser !== e.trunc) begin
					$error("out_truncated exp %b got %b", e.trunc, m_tuser); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("out_last exp %b got %b", e.last, m_tlast); errors++;
				end
				if (m_tlast === 1'b1) sets_done++;
			end
		end
	end

	// send one record; predicted after acceptance; valid stays up when no gap follows
	task automatic send_rec(input srv_rec_t rec, input logic last);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rec.tag, rec.port, rec.wgt, rec.prio};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_in++;
		order_record(rec, last);
	endtask

	task automatic write_seed(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		seed_reg = v;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (order_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic srv_rec_t rand_rec(input int prio_span, input int wgt_mode);
		srv_rec_t r;
		r.prio = (prio_span == 0) ? 16'($urandom) : 16'($urandom_range(0, prio_span));
		case (wgt_mode)
			0: r.wgt = 16'($urandom);
			1: r.wgt = 16'($urandom_range(0, 20));
			default: r.wgt = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 100));
		endcase
		r.port = 16'($urandom);
		r.tag = 16'($urandom);
		return r;
	endfunction

	// directed table: singletons with typed-in results, extremes, tie groups, zero weights
	row_t dir_rows[$];

	task automatic add_row(input srv_rec_t r, input logic last, input logic has_exp,
			input logic trunc);
		row_t x;
		x.rec = r;
		x.last = last;
		x.has_exp = has_exp;
		x.exp_beat.rec = r;
		x.exp_beat.trunc = trunc;
		x.exp_beat.last = 1'b1;
		dir_rows.push_back(x);
	endtask

	initial begin
		srv_rec_t r;
		int       i, n, set_len;
		ordered_t mine;
		errors = 0; beats_in = 0; beats_out = 0; sets_done = 0;
		held_count = 0; dropped = 0; seed_reg = 32'd1; gen_state = 32'd1;
		s_tvalid = 0; s_tdata = '0; s_tlast = 0;
		cfg_valid = 0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single records: output equals input, read straight off
		add_row({16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 1'b1, 1'b0);
		add_row({16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b1, 1'b1, 1'b0);
		add_row({16'h5a5a, 16'ha5a5, 16'h1234, 16'hedcb}, 1'b1, 1'b1, 1'b0);
		// priorities out of order, unsorted with ties
		add_row({16'd9, 16'd5, 16'd1, 16'd1}, 1'b0, 1'b0, 1'b0);
		add_row({16'd3, 16'd0, 16'd2, 16'd2}, 1'b0, 1'b0, 1'b0);
		add_row({16'd9, 16'd0, 16'd3, 16'd3}, 1'b0, 1'b0, 1'b0);
		add_row({16'd3, 16'hffff, 16'd4, 16'd4}, 1'b0, 1'b0, 1'b0);
		add_row({16'd3, 16'd7, 16'd5, 16'd5}, 1'b0, 1'b0, 1'b0);
		add_row({16'd0, 16'd1, 16'd6, 16'd6}, 1'b1, 1'b0, 1'b0);
		// one group, all zero weight
		add_row({16'd7, 16'd0, 16'd10, 16'd1}, 1'b0, 1'b0, 1'b0);
		add_row({16'd7, 16'd0, 16'd11, 16'd2}, 1'b0, 1'b0, 1'b0);
		add_row({16'd7, 16'd0, 16'd12, 16'd3}, 1'b1, 1'b0, 1'b0);
		// one group, heavy weights
		add_row({16'd2, 16'hffff, 16'd20, 16'd1}, 1'b0, 1'b0, 1'b0);
		add_row({16'd2, 16'hfffe, 16'd21, 16'd2}, 1'b0, 1'b0, 1'b0);
		add_row({16'd2, 16'd1, 16'd22, 16'd3}, 1'b1, 1'b0, 1'b0);
		foreach (dir_rows[k]) begin
			send_rec(dir_rows[k].rec, dir_rows[k].last);
			if (dir_rows[k].has_exp) begin
				// typed-in expectation must agree with the predictor's entry
				mine = order_q[order_q.size()-1];
				if (mine !== dir_rows[k].exp_beat) begin
					$error("directed row %0d exp %h got %h", k, dir_rows[k].exp_beat, mine);
					errors++;
				end
			end
		end
		// sender holds off until everything has come out
		drain;

		// seed zero falls back to one; then the extremes and random seeds
		write_seed(32'd0);
		for (i = 0; i < 3; i++) send_rec(rand_rec(1, 1), i == 2);
		drain;
		write_seed(32'hffff_ffff);

		// full set plus overflow, closing record itself dropped
		for (i = 0; i < MaxRecords + 2; i++) send_rec(rand_rec(3, 2), i == MaxRecords + 1);
		drain;
		// full set exactly, no drop
		for (i = 0; i < MaxRecords; i++) send_rec(rand_rec(0, 0), i == MaxRecords - 1);
		drain;

		// random sets, mostly small with tie-heavy priorities
		n = 0;
		while (n < 26) begin
			if ($urandom_range(0, 3) == 0) write_seed($urandom);
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
			for (i = 0; i < set_len; i++)
				send_rec(rand_rec(($urandom_range(0, 4) == 0) ? 0 : 3, $urandom_range(0, 2)),
					i == set_len - 1);
			n += set_len;
			drain;
		end
		drain;
		$display("sent %0d records, checked %0d ordered beats in %0d sets", beats_in,
			beats_out, sets_done);
		$display("covered singles, tie groups, zero weights, overflow and seed extremes");
		if (errors == 0 && order_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end
endmodule
